/* rtl/pcc_pkg.sv */
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types, constants and helpers for the clamped PID controller.
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int DATA_W   = 32;
    localparam int ISUM_W   = 48;
    localparam int TIME_W   = 64;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W = 3;

    // Shared multiplier: 48-bit by 32-bit magnitudes.
    localparam int MA_W   = 48;
    localparam int MB_W   = 32;
    localparam int PROD_W = MA_W + MB_W;

    // Shared divider: 64-bit dividend, 32-bit divisor.
    localparam int DIVD_W = 64;
    localparam int DIVS_W = 32;

    // Intermediate signed width able to hold a clipped value of +/- 2^33.
    localparam int WIDE_W = 35;

    localparam logic [DIVS_W-1:0] SCALE_SAMPLE = 32'd1000000;
    localparam logic [DIVS_W-1:0] SCALE_OWN    = 32'd1000;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_ERROR  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_TIME   = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT = 3'd0,
        REG_GAIN_P   = 3'd1,
        REG_GAIN_I   = 3'd2,
        REG_GAIN_D   = 3'd3,
        REG_UPPER    = 3'd4,
        REG_LOWER    = 3'd5,
        REG_GUARD    = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic            start;
        logic [MA_W-1:0] a;
        logic [MB_W-1:0] b;
        logic            neg;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
        logic              neg;
    } mul_rsp_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
        logic              neg;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIVD_W-1:0] quot;
        logic              neg;
    } div_rsp_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? 32'(-v) : 32'(v);
        return r;
    endfunction

    function automatic logic [47:0] mag48(input logic signed [47:0] v);
        logic [47:0] r;
        r = v[47] ? 48'(-v) : 48'(v);
        return r;
    endfunction

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [31:0] r;
        if (&v[WIDE_W-1:31] || ~|v[WIDE_W-1:31])
            r = v[31:0];
        else
            r = v[WIDE_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return r;
    endfunction

    // Saturate a 66-bit signed value to 48 bits.
    function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
        logic signed [47:0] r;
        if (&v[65:47] || ~|v[65:47])
            r = v[47:0];
        else
            r = v[65] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        return r;
    endfunction

    // Apply a sign to a 64-bit magnitude.
    function automatic logic signed [65:0] signed66(input logic [63:0] m, input logic neg);
        logic signed [65:0] r;
        r = $signed({2'b00, m});
        if (neg)
            r = -r;
        return r;
    endfunction

endpackage

/* rtl/pcc_mul.sv */
// ----------------------------------------------------------------------------
// pcc_mul
// Shared unsigned multiplier, 48 by 32 bits, built from two 32 by 32
// partial products and one add, done in sequence.
// ----------------------------------------------------------------------------
module pcc_mul
(
    input  logic              clk,
    input  logic              rst_n,
    input  pcc_pkg::mul_req_t req,
    output pcc_pkg::mul_rsp_t rsp
);
    import pcc_pkg::*;

    logic [MA_W-1:0]   a_reg;
    logic [MB_W-1:0]   b_reg;
    logic              neg_reg;
    logic [1:0]        phase_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [63:0]       lo_reg;
    logic [47:0]       hi_reg;
    logic [PROD_W-1:0] prod_reg;

    logic [31:0] x;
    logic [63:0] pp;

    assign x  = (phase_reg == 2'd0) ? a_reg[31:0] : {16'd0, a_reg[MA_W-1:32]};
    assign pp = x * b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                a_reg     <= req.a;
                b_reg     <= req.b;
                neg_reg   <= req.neg;
                phase_reg <= 2'd0;
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                case (phase_reg)
                    2'd0:
                    begin
                        lo_reg    <= pp;
                        phase_reg <= 2'd1;
                    end
                    2'd1:
                    begin
                        hi_reg    <= pp[47:0];
                        phase_reg <= 2'd2;
                    end
                    default:
                    begin
                        prod_reg <= {16'd0, lo_reg} + {hi_reg, 32'd0};
                        done_reg <= 1'b1;
                        busy_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = prod_reg;
    assign rsp.neg  = neg_reg;

endmodule

/* rtl/pcc_div.sv */
// ----------------------------------------------------------------------------
// pcc_div
// Shared unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcc_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  pcc_pkg::div_req_t req,
    output pcc_pkg::div_rsp_t rsp
);
    import pcc_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] quo_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;

    logic [DIVS_W:0] trial;
    logic            fits;

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                quo_reg <= req.dividend;
                rem_reg <= '0;
                dvs_reg <= req.divisor;
                neg_reg <= req.neg;
                cnt_reg <= CNT_W'(DIVD_W);
            end
            else if (cnt_reg != '0)
            begin
                rem_reg <= fits ? DIVS_W'(trial - {1'b0, dvs_reg}) : trial[DIVS_W-1:0];
                quo_reg <= {quo_reg[DIVD_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    done_reg <= 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.neg  = neg_reg;

endmodule

/* rtl/pid_controller_clamped_top.sv */
// ----------------------------------------------------------------------------
// pid_controller_clamped_top
// PID step with integral anti-windup and a clamped derivative, Q format data.
// ----------------------------------------------------------------------------
// Clear-integral and set-time beats are taken in the idle state and give no result.
// A sample or error beat runs two divisions normally, three when the
// integral is clamped, one when the elapsed time is zero; most of its
// work lies in the 64-step serial divider.
// One beat is in work at a time; the result register frees the input side.
// Reset is asynchronous, active low; it clears the controller state and
// returns the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module pid_controller_clamped_top
#(
    parameter int FRAC_BITS = pcc_pkg::FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pcc_pkg::DATA_W-1:0]        cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [95:0]                       s_tdata,   // sample[31:0], time_us[95:32]
    input  logic [pcc_pkg::OP_W-1:0]          s_tuser,   // opcode[1:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [127:0]                      m_tdata    // drive, p_term, i_term, d_term
);
    import pcc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DELTA, S_ED_GO, S_ED_MUL, S_ED_DIV, S_W_GO, S_W_MUL, S_W_DIV,
        S_D_GO, S_D_MUL, S_D_DIV, S_D_CLAMP, S_P_MUL, S_I_MUL, S_T_MUL, S_FIN
    } state_t;

    state_t state_reg;

    logic signed [31:0] setpoint_reg, gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [31:0] upper_reg, lower_reg;
    logic               guard_reg;

    logic signed [ISUM_W-1:0] isum_reg;
    logic signed [31:0]       perr_reg;
    logic [TIME_W-1:0]        ptime_reg;
    logic signed [31:0]       held_p_reg, held_i_reg, held_d_reg;

    opcode_t                  op_reg;
    logic signed [31:0]       err_reg;
    logic [TIME_W-1:0]        now_reg;
    logic signed [31:0]       delta_reg;
    logic signed [WIDE_W-1:0] dv_reg;
    logic signed [31:0]       dvc_reg;
    logic signed [31:0]       tp_reg, ti_reg, td_reg;
    logic                     out_valid_reg;
    logic [127:0]             out_data_reg;

    mul_req_t mreq_reg;
    mul_rsp_t mrsp;
    div_req_t dreq_reg;
    div_rsp_t drsp;

    pcc_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq_reg), .rsp(mrsp));
    pcc_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq_reg), .rsp(drsp));

    // Input fields.
    opcode_t            in_op;
    logic signed [31:0] in_sample;
    logic [TIME_W-1:0]  in_time;

    assign in_op     = opcode_t'(s_tuser);
    assign in_sample = $signed(s_tdata[31:0]);
    assign in_time   = s_tdata[95:32];

    // Error for the incoming beat.
    logic signed [WIDE_W-1:0] err_diff;
    logic signed [31:0]       err_in;

    assign err_diff = WIDE_W'(setpoint_reg) - WIDE_W'(in_sample);
    assign err_in   = (in_op == OP_SAMPLE) ? sat32(err_diff) : in_sample;

    // Elapsed time, saturated to a signed 32-bit microsecond count.
    logic [TIME_W-1:0]  raw_dt, neg_dt;
    logic signed [31:0] delta_w;

    assign raw_dt = now_reg - ptime_reg;
    assign neg_dt = ptime_reg - now_reg;

    always_comb
    begin
        if (raw_dt[TIME_W-1])
            delta_w = (neg_dt > 64'h8000_0000) ? 32'sh8000_0000 : $signed(raw_dt[31:0]);
        else
            delta_w = (raw_dt > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(raw_dt[31:0]);
    end

    logic [DIVS_W-1:0] scale_w;
    assign scale_w = (op_reg == OP_SAMPLE) ? SCALE_SAMPLE : SCALE_OWN;

    // Multiplier result in Q form, truncated and clipped to +/- 2^33.
    logic [PROD_W-1:0]        prod_sh;
    logic [33:0]              prod_mag;
    logic signed [WIDE_W-1:0] mulq_w;

    assign prod_sh  = mrsp.prod >> FRAC_BITS;
    assign prod_mag = (|prod_sh[PROD_W-1:33]) ? {1'b1, 33'd0} : prod_sh[33:0];
    assign mulq_w   = mrsp.neg ? -$signed({1'b0, prod_mag}) : $signed({1'b0, prod_mag});

    // Derivative quotient clipped the same way.
    logic [33:0]              quot_mag;
    logic signed [WIDE_W-1:0] quot_w;

    assign quot_mag = (|drsp.quot[DIVD_W-1:33]) ? {1'b1, 33'd0} : drsp.quot[33:0];
    assign quot_w   = drsp.neg ? -$signed({1'b0, quot_mag}) : $signed({1'b0, quot_mag});

    logic signed [WIDE_W-1:0] upper_w, lower_w;
    assign upper_w = WIDE_W'(upper_reg);
    assign lower_w = WIDE_W'(lower_reg);

    logic signed [65:0] isum_add;
    assign isum_add = 66'(isum_reg) + signed66(drsp.quot, drsp.neg);

    logic [DIVD_W-1:0] upper_shift, lower_shift;
    assign upper_shift = DIVD_W'(mag32(upper_reg)) << FRAC_BITS;
    assign lower_shift = DIVD_W'(mag32(lower_reg)) << FRAC_BITS;

    logic signed [32:0] diff_w;
    logic [32:0]        diff_mag;
    logic signed [WIDE_W-1:0] dv_zero;

    assign diff_w   = 33'(err_reg) - 33'(perr_reg);
    assign diff_mag = diff_w[32] ? 33'(-diff_w) : 33'(diff_w);

    always_comb
    begin
        if (diff_w[32])
            dv_zero = lower_w;
        else if (|diff_w)
            dv_zero = upper_w;
        else
            dv_zero = '0;
    end

    // The upper limit is tested first.
    logic signed [31:0] dv_clamp;
    always_comb
    begin
        if (dv_reg > upper_w)
            dv_clamp = upper_reg;
        else if (dv_reg < lower_w)
            dv_clamp = lower_reg;
        else
            dv_clamp = dv_reg[31:0];
    end

    logic signed [WIDE_W-1:0] sum_terms;
    assign sum_terms = WIDE_W'(tp_reg) + WIDE_W'(ti_reg) + WIDE_W'(td_reg);

    logic signed [31:0] p_out, i_out, d_out;
    assign p_out = (op_reg == OP_SAMPLE) ? tp_reg : held_p_reg;
    assign i_out = (op_reg == OP_SAMPLE) ? ti_reg : held_i_reg;
    assign d_out = (op_reg == OP_SAMPLE) ? td_reg : held_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg <= '0;
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
            upper_reg    <= 32'sh7FFF_FFFF;
            lower_reg    <= 32'sh8000_0000;
            guard_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SETPOINT: setpoint_reg <= $signed(cfg_data);
                REG_GAIN_P:   gain_p_reg   <= $signed(cfg_data);
                REG_GAIN_I:   gain_i_reg   <= $signed(cfg_data);
                REG_GAIN_D:   gain_d_reg   <= $signed(cfg_data);
                REG_UPPER:    upper_reg    <= $signed(cfg_data);
                REG_LOWER:    lower_reg    <= $signed(cfg_data);
                REG_GUARD:    guard_reg    <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            isum_reg      <= '0;
            perr_reg      <= '0;
            ptime_reg     <= '0;
            held_p_reg    <= '0;
            held_i_reg    <= '0;
            held_d_reg    <= '0;
            op_reg        <= OP_SAMPLE;
            mreq_reg      <= '0;
            dreq_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mreq_reg.start <= 1'b0;
            dreq_reg.start <= 1'b0;
            if (m_tready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        case (in_op)
                            OP_CLEAR: isum_reg  <= '0;
                            OP_TIME:  ptime_reg <= in_time;
                            default:
                            begin
                                op_reg    <= in_op;
                                err_reg   <= err_in;
                                now_reg   <= in_time;
                                state_reg <= S_DELTA;
                            end
                        endcase
                    end
                end
                S_DELTA:
                begin
                    delta_reg <= delta_w;
                    state_reg <= S_ED_GO;
                end
                S_ED_GO:
                begin
                    mreq_reg  <= {1'b1, MA_W'(mag32(err_reg)), mag32(delta_reg),
                                  err_reg[31] ^ delta_reg[31]};
                    state_reg <= S_ED_MUL;
                end
                S_ED_MUL:
                begin
                    if (mrsp.done)
                    begin
                        dreq_reg  <= {1'b1, mrsp.prod[DIVD_W-1:0], scale_w, mrsp.neg};
                        state_reg <= S_ED_DIV;
                    end
                end
                S_ED_DIV:
                begin
                    if (drsp.done)
                    begin
                        isum_reg  <= sat48(isum_add);
                        state_reg <= S_W_GO;
                    end
                end
                S_W_GO:
                begin
                    if (guard_reg && gain_i_reg != '0)
                    begin
                        mreq_reg  <= {1'b1, mag48(isum_reg), mag32(gain_i_reg),
                                      isum_reg[ISUM_W-1] ^ gain_i_reg[31]};
                        state_reg <= S_W_MUL;
                    end
                    else
                        state_reg <= S_D_GO;
                end
                S_W_MUL:
                begin
                    if (mrsp.done)
                    begin
                        if (mulq_w > upper_w)
                        begin
                            dreq_reg  <= {1'b1, upper_shift, mag32(gain_i_reg),
                                          upper_reg[31] ^ gain_i_reg[31]};
                            state_reg <= S_W_DIV;
                        end
                        else if (mulq_w < lower_w)
                        begin
                            dreq_reg  <= {1'b1, lower_shift, mag32(gain_i_reg),
                                          lower_reg[31] ^ gain_i_reg[31]};
                            state_reg <= S_W_DIV;
                        end
                        else
                            state_reg <= S_D_GO;
                    end
                end
                S_W_DIV:
                begin
                    if (drsp.done)
                    begin
                        isum_reg  <= sat48(signed66(drsp.quot, drsp.neg));
                        state_reg <= S_D_GO;
                    end
                end
                S_D_GO:
                begin
                    if (delta_reg == '0)
                    begin
                        dv_reg    <= dv_zero;
                        state_reg <= S_D_CLAMP;
                    end
                    else
                    begin
                        mreq_reg  <= {1'b1, MA_W'(diff_mag), scale_w, diff_w[32]};
                        state_reg <= S_D_MUL;
                    end
                end
                S_D_MUL:
                begin
                    if (mrsp.done)
                    begin
                        dreq_reg  <= {1'b1, mrsp.prod[DIVD_W-1:0], mag32(delta_reg),
                                      mrsp.neg ^ delta_reg[31]};
                        state_reg <= S_D_DIV;
                    end
                end
                S_D_DIV:
                begin
                    if (drsp.done)
                    begin
                        dv_reg    <= quot_w;
                        state_reg <= S_D_CLAMP;
                    end
                end
                S_D_CLAMP:
                begin
                    dvc_reg   <= dv_clamp;
                    perr_reg  <= err_reg;
                    mreq_reg  <= {1'b1, MA_W'(mag32(err_reg)), mag32(gain_p_reg),
                                  err_reg[31] ^ gain_p_reg[31]};
                    state_reg <= S_P_MUL;
                end
                S_P_MUL:
                begin
                    if (mrsp.done)
                    begin
                        tp_reg    <= sat32(mulq_w);
                        mreq_reg  <= {1'b1, mag48(isum_reg), mag32(gain_i_reg),
                                      isum_reg[ISUM_W-1] ^ gain_i_reg[31]};
                        state_reg <= S_I_MUL;
                    end
                end
                S_I_MUL:
                begin
                    if (mrsp.done)
                    begin
                        ti_reg    <= sat32(mulq_w);
                        mreq_reg  <= {1'b1, MA_W'(mag32(dvc_reg)), mag32(gain_d_reg),
                                      dvc_reg[31] ^ gain_d_reg[31]};
                        state_reg <= S_T_MUL;
                    end
                end
                S_T_MUL:
                begin
                    if (mrsp.done)
                    begin
                        td_reg    <= sat32(mulq_w);
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    // Wait here only while an earlier result is still held.
                    if (!out_valid_reg || m_tready)
                    begin
                        out_data_reg  <= {d_out, i_out, p_out, sat32(sum_terms)};
                        out_valid_reg <= 1'b1;
                        held_p_reg    <= p_out;
                        held_i_reg    <= i_out;
                        held_d_reg    <= d_out;
                        ptime_reg     <= now_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* rtl/pcc_checker.sv */
// ----------------------------------------------------------------------------
// pcc_checker
// Port-level assertions for the clamped PID controller, bound to the top.
// ----------------------------------------------------------------------------
module pcc_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [pcc_pkg::OP_W-1:0]      s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [127:0]                  m_tdata
);
    import pcc_pkg::*;

    // A sample or error beat occupies the block, so the input is not ready afterwards.
    a_busy_after_step: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == OP_SAMPLE || s_tuser == OP_ERROR))
        |=> !s_tready)
        else $error("input still ready after a control step was taken");

    // Clear and time-reference beats finish at once.
    a_ready_after_ctl: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == OP_CLEAR || s_tuser == OP_TIME))
        |=> s_tready)
        else $error("input not ready after a clear or time beat");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped before it was taken");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind pid_controller_clamped_top pcc_checker u_pcc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
